FILE: design/bgp_pkg.sv
package bgp_pkg;

	localparam int GRADE_W = 5;

	typedef logic signed [1:0] sign_t;

	localparam sign_t SIGN_ZERO = 2'sb00;
	localparam sign_t SIGN_PLUS = 2'sb01;
	localparam sign_t SIGN_MINUS = 2'sb11;

	// Parity and overlap flags that one blade part hands to the sign logic.
	typedef struct packed {
		logic inpart_par;
		logic shared_par;
		logic left_par;
		logic right_par;
		logic overlap;
	} part_flags_t;

endpackage

FILE: design/bgp_part.sv
module bgp_part import bgp_pkg::*; #(
	parameter int W = 8
) (
	input  logic [W-1:0]         left,
	input  logic [W-1:0]         right,
	output logic [W-1:0]         prod,
	output logic [$clog2(W+1)-1:0] count,
	output part_flags_t          flags
);

	localparam int CNT_W = $clog2(W + 1);

	logic [W-1:0] pass_term;
	logic [W-1:0] shared;

	// A left vector at bit i passes every right vector below it; only the parity matters.
	for (genvar i = 0; i < W; i++) begin : g_pass
		if (i == 0) begin : g_first
			assign pass_term[i] = 1'b0;
		end else begin : g_rest
			assign pass_term[i] = left[i] & (^right[i-1:0]);
		end
	end

	assign prod = left ^ right;
	assign shared = left & right;

	always_comb begin
		count = '0;
		for (int k = 0; k < W; k++) begin
			count = count + CNT_W'(prod[k]);
		end
	end

	assign flags.inpart_par = ^pass_term;
	assign flags.shared_par = ^shared;
	assign flags.left_par = ^left;
	assign flags.right_par = ^right;
	assign flags.overlap = |shared;

endmodule

FILE: design/blade_geometric_product_top.sv
// Channel | Handshake            | Words
// input   | in_valid / in_ready  | left_pos, left_neg, left_null, right_pos, right_neg, right_null
// output  | out_valid / out_ready| prod_sign, prod_pos, prod_neg, prod_null, prod_grade
//
// One word per cycle is accepted and delivered while out_ready stays high; each accepted word
// passes the input register, then the result register, with the bitmap logic between them,
// and is shown on the output from the result register.
// The single result register is refilled whenever it may advance and stage 1 holds a word.
// Reset clears only the two stage valid flags; the block is ready right after reset.
// A stalled output holds the result register and the input register behind it; in_ready
// drops only when both stages are full and out_ready is low.
module blade_geometric_product_top import bgp_pkg::*; #(
	parameter int POS_DIM = 8,
	parameter int NEG_DIM = 4,
	parameter int NULL_DIM = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [POS_DIM-1:0]  left_pos,
	input  logic [NEG_DIM-1:0]  left_neg,
	input  logic [NULL_DIM-1:0] left_null,
	input  logic [POS_DIM-1:0]  right_pos,
	input  logic [NEG_DIM-1:0]  right_neg,
	input  logic [NULL_DIM-1:0] right_null,
	output logic                out_valid,
	input  logic                out_ready,
	output sign_t               prod_sign,
	output logic [POS_DIM-1:0]  prod_pos,
	output logic [NEG_DIM-1:0]  prod_neg,
	output logic [NULL_DIM-1:0] prod_null,
	output logic [GRADE_W-1:0]  prod_grade
);

	localparam int POS_CW = $clog2(POS_DIM + 1);
	localparam int NEG_CW = $clog2(NEG_DIM + 1);
	localparam int NULL_CW = $clog2(NULL_DIM + 1);
	localparam int TOTAL_CW = $clog2(POS_DIM + NEG_DIM + NULL_DIM + 1);
	localparam int SUM_W = (TOTAL_CW > GRADE_W) ? TOTAL_CW : GRADE_W;

	logic                valid_s1;
	logic                valid_s2;
	logic                adv_s2;
	logic                adv_s1;

	logic [POS_DIM-1:0]  lp_s1;
	logic [NEG_DIM-1:0]  ln_s1;
	logic [NULL_DIM-1:0] lz_s1;
	logic [POS_DIM-1:0]  rp_s1;
	logic [NEG_DIM-1:0]  rn_s1;
	logic [NULL_DIM-1:0] rz_s1;

	logic [POS_DIM-1:0]  yp;
	logic [NEG_DIM-1:0]  yn;
	logic [NULL_DIM-1:0] yz;
	logic [POS_CW-1:0]   cnt_p;
	logic [NEG_CW-1:0]   cnt_n;
	logic [NULL_CW-1:0]  cnt_z;
	part_flags_t         fl_p;
	part_flags_t         fl_n;
	part_flags_t         fl_z;
	logic [SUM_W-1:0]    grade_sum;
	logic                parity;
	sign_t               sign_d;

	sign_t               sign_s2;
	logic [POS_DIM-1:0]  yp_s2;
	logic [NEG_DIM-1:0]  yn_s2;
	logic [NULL_DIM-1:0] yz_s2;
	logic [GRADE_W-1:0]  grade_s2;

	assign adv_s2 = !valid_s2 || out_ready;
	assign adv_s1 = !valid_s1 || adv_s2;
	assign in_ready = adv_s1;

	bgp_part #(.W(POS_DIM)) u_pos (
		.left(lp_s1), .right(rp_s1), .prod(yp), .count(cnt_p), .flags(fl_p)
	);
	bgp_part #(.W(NEG_DIM)) u_neg (
		.left(ln_s1), .right(rn_s1), .prod(yn), .count(cnt_n), .flags(fl_n)
	);
	bgp_part #(.W(NULL_DIM)) u_null (
		.left(lz_s1), .right(rz_s1), .prod(yz), .count(cnt_z), .flags(fl_z)
	);

	assign grade_sum = SUM_W'(cnt_p) + SUM_W'(cnt_n) + SUM_W'(cnt_z);

	// Cross-part swaps: left neg past right pos, left null past right pos and neg,
	// each weighted by the grades involved, so only the parities of both sides count.
	assign parity = fl_n.shared_par ^ fl_p.inpart_par ^ fl_n.inpart_par ^ fl_z.inpart_par
		^ (fl_n.left_par & fl_p.right_par)
		^ (fl_z.left_par & (fl_p.right_par ^ fl_n.right_par));

	always_comb begin
		if (fl_z.overlap) begin
			sign_d = SIGN_ZERO;
		end else if (parity) begin
			sign_d = SIGN_MINUS;
		end else begin
			sign_d = SIGN_PLUS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (adv_s1) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			lp_s1 <= left_pos;
			ln_s1 <= left_neg;
			lz_s1 <= left_null;
			rp_s1 <= right_pos;
			rn_s1 <= right_neg;
			rz_s1 <= right_null;
		end
		if (adv_s2 && valid_s1) begin
			sign_s2 <= sign_d;
			yp_s2 <= yp;
			yn_s2 <= yn;
			yz_s2 <= yz;
			grade_s2 <= grade_sum[GRADE_W-1:0];
		end
	end

	assign out_valid = valid_s2;
	assign prod_sign = sign_s2;
	assign prod_pos = yp_s2;
	assign prod_neg = yn_s2;
	assign prod_null = yz_s2;
	assign prod_grade = grade_s2;

endmodule
